>>> src/running_variance_tracker_defines.svh
// Assertion macros for the running variance tracker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef RUNNING_VARIANCE_TRACKER_DEFINES_SVH
`define RUNNING_VARIANCE_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define RVT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rvt check failed");

// Next-cycle implication, disabled in reset.
`define RVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rvt check failed");

`endif

>>> src/rvt_pkg.sv
// Shared types and constants of the running variance tracker.
// No dependencies.
`default_nettype none

package rvt_pkg;

  localparam int MEAN_W     = 32;
  localparam int SUM_W      = 64;
  localparam int VAR_W      = 48;
  localparam int STD_W      = 24;
  localparam int CNT_OUT_W  = 16;
  localparam int PROD_SHIFT = 16;
  localparam int TD_OUT_W   = 120;
  localparam int DIV_CNT_W  = 7;
  localparam int SQ_CNT_W   = 5;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_REPLACE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIVM,
    S_MOPS,
    S_MUL,
    S_SUM,
    S_VAR,
    S_DIVV,
    S_SQI,
    S_SQRT,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

>>> src/rvt_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rvt_pkg.
`default_nettype none

module rvt_div
  import rvt_pkg::*;
#(
  parameter int DIVISOR_W = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [SUM_W-1:0]     dividend,
  input  wire logic [DIVISOR_W-1:0] divisor,
  output logic                      done,
  output logic [SUM_W-1:0]          quotient
);

  logic [DIVISOR_W:0]   rem_r;
  logic [SUM_W-1:0]     quo_r;
  logic [DIVISOR_W-1:0] dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIVISOR_W:0] shifted;
  logic               ge;

  assign shifted = {rem_r[DIVISOR_W-1:0], quo_r[SUM_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? (shifted - {1'b0, dvs_r}) : shifted;
      quo_r <= {quo_r[SUM_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> src/running_variance_tracker.sv
// Running mean / variance / standard deviation tracker (Welford update).
// Depends on rvt_pkg, rvt_div and running_variance_tracker_defines.svh.
//
// One request at a time: each request (add, remove, replace, clear) updates
// count, Q15.16 mean and the Q.16 sum of squared deviations, then one result
// carries count, mean, variance (sum / count, Q32.16, saturated) and the
// exact integer square root of the variance (Q16.8). All arithmetic is bit
// serial: a shared restoring divider gives one quotient bit per cycle (used
// once for the mean step, once for the variance), a shift-add multiplier
// takes one multiplier bit per cycle, and the square root takes two
// radicand bits per cycle. Refused requests, clears and removal of the last
// sample skip the mean and multiply steps, and the variance division is
// skipped when the count ends at zero. A new request is taken only when the
// sequencer is idle; the output register holds the last result until it is
// taken.
`default_nettype none
`include "running_variance_tracker_defines.svh"

module running_variance_tracker
  import rvt_pkg::*;
#(
  parameter int COUNT_BITS  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_tvalid,
  output logic                                           in_tready,
  // [SAMPLE_BITS-1:0] sample, [2*SAMPLE_BITS-1:SAMPLE_BITS] old_sample
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        in_tdata,
  // [1:0] opcode
  input  wire logic [1:0]                                in_tuser,
  output logic                                           out_tvalid,
  input  wire logic                                      out_tready,
  // [15:0] sample_count, [47:16] mean_value, [95:48] variance_value,
  // [119:96] std_deviation
  output logic [TD_OUT_W-1:0]                            out_tdata,
  // [0] error_flag
  output logic                                           out_tuser
);

  localparam int XW  = SAMPLE_BITS + PROD_SHIFT;
  localparam int WW  = ((XW > MEAN_W) ? XW : MEAN_W) + 4;  // signed work width
  localparam int M   = WW - 1;                             // magnitude width
  localparam int PW  = 2 * M;
  localparam int PPW = ((PW > SUM_W + PROD_SHIFT) ? PW : SUM_W + PROD_SHIFT) + 1;
  localparam int MCW = $clog2(M + 1);

  // ---------------------------------------------------------------- state
  state_t state_r, state_nxt;

  logic [COUNT_BITS-1:0]    count_r;
  logic signed [MEAN_W-1:0] mean_r;
  logic [SUM_W-1:0]         sum_r;

  op_t                      op_r;
  logic signed [WW-1:0]     x_r, xo_r;
  logic                     err_r;
  logic                     eneg_r;
  logic signed [MEAN_W-1:0] mnew_r;

  // multiplier
  logic [PW-1:0]  mp_r;
  logic [M-1:0]   ma_r;
  logic [MCW-1:0] mcnt_r;
  logic           mneg_r;

  // variance and square root
  logic [VAR_W-1:0]    var_r;
  logic [VAR_W-1:0]    rad_r;
  logic [STD_W+1:0]    srem_r;
  logic [STD_W-1:0]    root_r;
  logic [SQ_CNT_W-1:0] scnt_r;

  // output register
  logic                out_valid_r;
  logic [TD_OUT_W-1:0] out_tdata_r;
  logic                out_tuser_r;

  // ---------------------------------------------------------------- input
  logic                   in_acc;
  logic signed [WW-1:0]   x_in, xo_in;
  logic [SAMPLE_BITS-1:0] smp, osmp;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign smp       = in_tdata[SAMPLE_BITS-1:0];
  assign osmp      = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign x_in  = {{(WW-XW){smp[SAMPLE_BITS-1]}}, smp, {PROD_SHIFT{1'b0}}};
  assign xo_in = {{(WW-XW){osmp[SAMPLE_BITS-1]}}, osmp, {PROD_SHIFT{1'b0}}};

  // ---------------------------------------------------------------- decode
  logic cnt_zero, cnt_one, cnt_full;
  assign cnt_zero = (count_r == '0);
  assign cnt_one  = (count_r == COUNT_BITS'(1));
  assign cnt_full = (count_r == '1);

  logic do_err, do_clear;
  always_comb begin
    do_err   = 1'b0;
    do_clear = 1'b0;
    unique case (op_r)
      OP_ADD:     do_err = cnt_full;
      OP_REMOVE: begin
        do_err   = cnt_zero;
        do_clear = cnt_one;
      end
      OP_REPLACE: do_err = cnt_zero;
      OP_CLEAR:   do_clear = 1'b1;
      default:    do_err = 1'b0;
    endcase
  end

  logic signed [WW-1:0] mext;
  logic signed [WW-1:0] e_val;
  logic [M-1:0]         e_mag;
  assign mext  = {{(WW-MEAN_W){mean_r[MEAN_W-1]}}, mean_r};
  assign e_val = (op_r == OP_REPLACE) ? (x_r - xo_r) : (x_r - mext);
  assign e_mag = e_val[WW-1] ? M'(-e_val) : M'(e_val);

  // ---------------------------------------------------------------- divider
  logic                  div_start, div_done;
  logic [SUM_W-1:0]      div_dividend, div_quo;
  logic [COUNT_BITS-1:0] div_divisor;

  always_comb begin
    if (state_r == S_PREP) begin
      div_dividend = {{(SUM_W-M){1'b0}}, e_mag};
      case (op_r)
        OP_ADD:    div_divisor = count_r + 1'b1;
        OP_REMOVE: div_divisor = count_r - 1'b1;
        default:   div_divisor = count_r;
      endcase
    end else begin
      div_dividend = sum_r;
      div_divisor  = count_r;
    end
  end

  rvt_div #(
    .DIVISOR_W(COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------- mean step
  logic signed [WW:0]       m1, qz, mcalc;
  logic                     up_dir;
  logic signed [MEAN_W-1:0] mclamp;

  assign m1     = {mean_r[MEAN_W-1], mext};
  assign qz     = {2'b00, div_quo[M-1:0]};
  assign up_dir = (op_r != OP_REMOVE) ^ eneg_r;
  assign mcalc  = up_dir ? (m1 + qz) : (m1 - qz);

  always_comb begin
    if (!mcalc[WW] && (|mcalc[WW-1:MEAN_W-1])) begin
      mclamp = {1'b0, {(MEAN_W-1){1'b1}}};
    end else if (mcalc[WW] && !(&mcalc[WW-1:MEAN_W-1])) begin
      mclamp = {1'b1, {(MEAN_W-1){1'b0}}};
    end else begin
      mclamp = mcalc[MEAN_W-1:0];
    end
  end

  // product operands
  logic signed [WW-1:0] mn, opa, opb;
  logic                 neg_sum;
  assign mn = {{(WW-MEAN_W){mnew_r[MEAN_W-1]}}, mnew_r};

  always_comb begin
    case (op_r)
      OP_ADD: begin
        opa = x_r - mn;
        opb = x_r - mext;
      end
      OP_REMOVE: begin
        opa = x_r - mext;
        opb = x_r - mn;
      end
      default: begin
        opa = x_r - xo_r;
        opb = (x_r - mn) + (xo_r - mext);
      end
    endcase
    neg_sum = opa[WW-1] ^ opb[WW-1] ^ (op_r == OP_REMOVE);
  end

  // shift-add multiplier step
  logic [M:0] mup;
  assign mup = {1'b0, mp_r[PW-1:M]} + (mp_r[0] ? {1'b0, ma_r} : {(M+1){1'b0}});

  // product >> 16, saturated to the sum width
  logic [PPW-1:0]   pe;
  logic [SUM_W-1:0] pv;
  logic [SUM_W:0]   s_add;
  logic [SUM_W-1:0] sum_upd;
  assign pe    = {{(PPW-PW){1'b0}}, mp_r};
  assign pv    = (|pe[PPW-1:SUM_W+PROD_SHIFT]) ? {SUM_W{1'b1}}
                                               : pe[SUM_W+PROD_SHIFT-1:PROD_SHIFT];
  assign s_add = {1'b0, sum_r} + {1'b0, pv};

  always_comb begin
    if (mneg_r) begin
      sum_upd = (sum_r >= pv) ? (sum_r - pv) : {SUM_W{1'b0}};
    end else begin
      sum_upd = s_add[SUM_W] ? {SUM_W{1'b1}} : s_add[SUM_W-1:0];
    end
  end

  // square root step: two radicand bits per cycle
  logic [STD_W+1:0] srem_sh, strial;
  logic             sge;
  assign srem_sh = {srem_r[STD_W-1:0], rad_r[VAR_W-1:VAR_W-2]};
  assign strial  = {root_r, 2'b01};
  assign sge     = srem_sh >= strial;

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_PREP;
      S_PREP: begin
        if (do_err || do_clear) begin
          state_nxt = S_VAR;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIVM;
        end
      end
      S_DIVM: if (div_done) state_nxt = S_MOPS;
      S_MOPS: state_nxt = S_MUL;
      S_MUL:  if (mcnt_r == MCW'(1)) state_nxt = S_SUM;
      S_SUM:  state_nxt = S_VAR;
      S_VAR: begin
        if (cnt_zero) begin
          state_nxt = S_SQI;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIVV;
        end
      end
      S_DIVV: if (div_done) state_nxt = S_SQI;
      S_SQI:  state_nxt = S_SQRT;
      S_SQRT: if (scnt_r == SQ_CNT_W'(1)) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mean_r  <= '0;
      sum_r   <= '0;
    end else if (state_r == S_PREP && do_clear && !do_err) begin
      count_r <= '0;
      mean_r  <= '0;
      sum_r   <= '0;
    end else if (state_r == S_SUM) begin
      sum_r  <= sum_upd;
      mean_r <= mnew_r;
      if (op_r == OP_ADD) begin
        count_r <= count_r + 1'b1;
      end else if (op_r == OP_REMOVE) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // working registers (payload, no reset)
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r <= op_t'(in_tuser);
          x_r  <= x_in;
          xo_r <= xo_in;
        end
      end
      S_PREP: begin
        err_r  <= do_err;
        eneg_r <= e_val[WW-1];
      end
      S_DIVM: if (div_done) mnew_r <= mclamp;
      S_MOPS: begin
        ma_r   <= opa[WW-1] ? M'(-opa) : M'(opa);
        mp_r   <= {{M{1'b0}}, (opb[WW-1] ? M'(-opb) : M'(opb))};
        mcnt_r <= MCW'(M);
        mneg_r <= neg_sum;
      end
      S_MUL: begin
        mp_r   <= {mup, mp_r[M-1:1]};
        mcnt_r <= mcnt_r - 1'b1;
      end
      S_VAR: if (cnt_zero) var_r <= '0;
      S_DIVV: begin
        if (div_done) begin
          var_r <= (|div_quo[SUM_W-1:VAR_W]) ? {VAR_W{1'b1}} : div_quo[VAR_W-1:0];
        end
      end
      S_SQI: begin
        rad_r  <= var_r;
        srem_r <= '0;
        root_r <= '0;
        scnt_r <= SQ_CNT_W'(STD_W);
      end
      S_SQRT: begin
        rad_r  <= {rad_r[VAR_W-3:0], 2'b00};
        srem_r <= sge ? (srem_sh - strial) : srem_sh;
        root_r <= {root_r[STD_W-2:0], sge};
        scnt_r <= scnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  logic [COUNT_BITS+CNT_OUT_W-1:0] cnt_ext;
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_tdata_r <= {root_r, var_r, mean_r, cnt_ext[CNT_OUT_W-1:0]};
      out_tuser_r <= err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------------------------------------------------------- checks
  // An accepted request always starts decode on the next cycle.
  `RVT_ASSERT_NEXT(a_accept_prep, in_tvalid && in_tready, state_r == S_PREP)
  // An empty tracker carries no mean and no spread.
  `RVT_ASSERT_NOW(a_empty_clean, count_r == '0, (sum_r == '0) && (mean_r == '0))
  // A result only appears out of the result-load state.
  `RVT_ASSERT_NOW(a_out_source, $rose(out_valid_r), $past(state_r) == S_OUT)

endmodule

`default_nettype wire

>>> verif/tb_running_variance_tracker.sv
// Self-checking testbench of running_variance_tracker: directed and random requests
// are checked against an in-bench Welford predictor. Depends on rvt_pkg and the RTL.
`default_nettype none

module tb_running_variance_tracker
  import rvt_pkg::*;
();

  // Count width as the block's default.
  localparam int CNT_BITS = 16;
  localparam int SMP_BITS = 16;
  localparam logic [63:0] CNT_FULL = (64'd1 << CNT_BITS) - 1;
  localparam logic [63:0] VAR_MAX = (64'd1 << VAR_W) - 1;

  typedef struct packed {
    op_t         op;
    logic [15:0] smp;
    logic [15:0] old_smp;
  } request_t;

  typedef struct packed {
    logic [15:0] count;
    logic [31:0] mean;
    logic [47:0] variance;
    logic [23:0] std_dev;
    logic        err;
  } stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;   // [15:0] sample, [31:16] old_sample
  logic [1:0] in_tuser = '0;    // [1:0] opcode
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TD_OUT_W-1:0] out_tdata; // count, mean, variance, std_deviation
  logic out_tuser;              // [0] error_flag

  request_t pending_reqs[$];
  stats_t   expected_stats[$];
  int       err_total = 0;
  int       results_seen = 0;
  int       refusals_seen = 0;
  int       in_gap = 0;
  int       out_gap = 0;
  bit       busy_phase = 1'b1;  // when clear, neither side idles

  // predictor state
  logic [63:0] trk_count = '0;
  longint      trk_mean = 0;
  logic [63:0] trk_sum = '0;

  always #2 clk = ~clk;

  running_variance_tracker #(.COUNT_BITS(CNT_BITS), .SAMPLE_BITS(SMP_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  function automatic int pick_gap();
    if (!busy_phase) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  function automatic longint sat_mean(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // sum +/-= (|a|*|b|) >> 16, with sign of a*b, saturating at both ends
  function automatic void fold_product(longint a, longint b, bit negate);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] full_p;
    logic [63:0]  p;
    bit           neg;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    full_p = {64'd0, ma} * {64'd0, mb};
    p = (full_p[127:80] != 0) ? '1 : full_p[79:16];
    neg = ((a < 0) != (b < 0)) != negate;
    if (p == 0) return;
    if (neg) trk_sum = (trk_sum >= p) ? trk_sum - p : '0;
    else trk_sum = (~trk_sum >= p) ? trk_sum + p : '1;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Welford update for one request; returns the stats it should report.
  function automatic stats_t apply_request(request_t r);
    longint      x;
    longint      xo;
    longint      m_old;
    longint      m_new;
    longint      d;
    logic [63:0] var_q;
    stats_t      s;
    x = longint'($signed(r.smp)) * 65536;
    xo = longint'($signed(r.old_smp)) * 65536;
    m_old = trk_mean;
    s.err = 1'b0;
    var_q = '0;
    case (r.op)
      OP_ADD: begin
        if (trk_count >= CNT_FULL) begin
          s.err = 1'b1;
        end else begin
          m_new = sat_mean(m_old + (x - m_old) / longint'(trk_count + 1));
          fold_product(x - m_new, x - m_old, 1'b0);
          trk_mean = m_new;
          trk_count++;
        end
      end
      OP_REMOVE: begin
        if (trk_count == 0) begin
          s.err = 1'b1;
        end else if (trk_count == 1) begin
          trk_count = '0; trk_mean = 0; trk_sum = '0;
        end else begin
          m_new = sat_mean(m_old - (x - m_old) / longint'(trk_count - 1));
          fold_product(x - m_old, x - m_new, 1'b1);
          trk_mean = m_new;
          trk_count--;
        end
      end
      OP_REPLACE: begin
        if (trk_count == 0) begin
          s.err = 1'b1;
        end else begin
          d = x - xo;
          m_new = sat_mean(m_old + d / longint'(trk_count));
          fold_product(d, (x - m_new) + (xo - m_old), 1'b0);
          trk_mean = m_new;
        end
      end
      default: begin
        trk_count = '0; trk_mean = 0; trk_sum = '0;
      end
    endcase
    if (trk_count != 0) begin
      var_q = trk_sum / trk_count;
      if (var_q > VAR_MAX) var_q = VAR_MAX;
    end
    s.count = trk_count[15:0];
    s.mean = trk_mean[31:0];
    s.variance = var_q[47:0];
    s.std_dev = 24'(int_sqrt(var_q));
    return s;
  endfunction

  // Driver: one nonblocking write per signal per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0 || pending_reqs.size() == 0) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else begin
        request_t r;
        r = pending_reqs.pop_front();
        in_tdata <= {r.old_smp, r.smp};
        in_tuser <= r.op;
        in_tvalid <= 1'b1;
        in_gap <= pick_gap();
      end
    end
  end

  // Result-side back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_tvalid && out_tready) out_gap <= pick_gap();
    end
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        stats_t e;
        stats_t a;
        a.count = out_tdata[15:0];
        a.mean = out_tdata[47:16];
        a.variance = out_tdata[95:48];
        a.std_dev = out_tdata[119:96];
        a.err = out_tuser;
        results_seen++;
        if (a.err) refusals_seen++;
        if (expected_stats.size() == 0) begin
          $error("result with no request outstanding");
          err_total++;
        end else begin
          e = expected_stats.pop_front();
          if (a.count != e.count) begin
            $error("sample_count exp %0d got %0d", e.count, a.count); err_total++;
          end
          if (a.mean != e.mean) begin
            $error("mean_value exp %h got %h", e.mean, a.mean); err_total++;
          end
          if (a.variance != e.variance) begin
            $error("variance_value exp %h got %h", e.variance, a.variance); err_total++;
          end
          if (a.std_dev != e.std_dev) begin
            $error("std_deviation exp %h got %h", e.std_dev, a.std_dev); err_total++;
          end
          if (a.err != e.err) begin
            $error("error_flag exp %0d got %0d", e.err, a.err); err_total++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_stats.push_back(apply_request({op_t'(in_tuser), in_tdata[15:0],
                                                in_tdata[31:16]}));
    end
  end

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 40)) - 16'd20;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic queue_req(op_t op, logic [15:0] s, logic [15:0] so);
    pending_reqs.push_back('{op, s, so});
  endtask

  initial begin
    int k;
    // directed: refusals on empty, extremes, mean saturation
    queue_req(OP_REMOVE, 16'h0001, 16'h0000);
    queue_req(OP_REPLACE, 16'h7fff, 16'h8000);
    queue_req(OP_ADD, 16'h7fff, 16'hffff);
    queue_req(OP_REMOVE, 16'h7fff, 16'h0000);   // last sample out
    queue_req(OP_ADD, 16'h8000, 16'h0000);
    queue_req(OP_ADD, 16'h8000, 16'h0000);
    queue_req(OP_REMOVE, 16'h7fff, 16'h0000);   // drives mean past the low end
    queue_req(OP_CLEAR, 16'hffff, 16'hffff);
    queue_req(OP_ADD, 16'h7fff, 16'h0000);
    queue_req(OP_ADD, 16'h7fff, 16'h0000);
    queue_req(OP_REMOVE, 16'h8000, 16'h0000);   // mean past the high end
    queue_req(OP_REPLACE, 16'h8000, 16'h7fff);
    for (k = 0; k < 11; k++) queue_req(OP_ADD, 16'(k * 3000), 16'h5555);
    queue_req(OP_ADD, 16'h1234, 16'h0000);
    queue_req(OP_REPLACE, 16'h7fff, 16'h8000);
    queue_req(OP_CLEAR, 16'h0000, 16'h0000);

    for (k = 0; k < 800; k++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) queue_req(OP_ADD, rand_sample(), rand_sample());
      else if (r < 65) queue_req(OP_REMOVE, rand_sample(), rand_sample());
      else if (r < 92) queue_req(OP_REPLACE, rand_sample(), rand_sample());
      else queue_req(OP_CLEAR, rand_sample(), rand_sample());
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() != 0 || in_tvalid) begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) busy_phase = ~busy_phase;
    end
    busy_phase = 1'b1;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("covered %0d results, %0d refused; add/remove/replace/clear, empty tracker",
             results_seen, refusals_seen);
    if (err_total == 0 && expected_stats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout waiting for results");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
